// ===== rtl/dcvlc_pkg.sv =====
// shared types, constants and scan order for the dct coefficient vlc decoder
// no dependencies
package dcvlc_pkg;

  localparam int FirstTableDepth = 512;
  localparam int SubTableDepth   = 256;
  localparam int QuantWidth      = 16;
  localparam int QuantDepth      = 64;
  localparam int FirstAw         = $clog2(FirstTableDepth);
  localparam int SubAw           = $clog2(SubTableDepth);
  localparam int QuantAw         = $clog2(QuantDepth);
  localparam int BufBits         = 48;
  localparam int NeedBits        = 22;
  localparam int ResultLimit     = 16;
  localparam int FlagSubBit      = 4;   // 0x10
  localparam int FlagEscBit      = 5;   // 0x20
  localparam int MaxShortLen     = 9;
  localparam int EscLen          = 22;
  localparam int EobLen          = 2;
  localparam int DcLen           = 8;
  localparam int LastIndex       = 63;

  typedef enum logic [2:0] {
    ACT_WORD        = 3'd0,
    ACT_LOAD_FIRST  = 3'd1,
    ACT_LOAD_SECOND = 3'd2,
    ACT_LOAD_THIRD  = 3'd3,
    ACT_LOAD_QUANT  = 3'd4
  } dcvlc_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAB1,
    ST_TAB2,
    ST_APPLY,
    ST_QUANT,
    ST_EMIT
  } dcvlc_state_e;

  typedef struct packed {
    logic                  first_we;
    logic                  second_we;
    logic                  third_we;
    logic                  quant_we;
    logic [FirstAw-1:0]    addr;
    logic [31:0]           value;
  } dcvlc_wr_t;

  typedef struct packed {
    logic [FirstAw-1:0] first_addr;
    logic [SubAw-1:0]   sub_addr;
    logic [QuantAw-1:0] quant_addr;
  } dcvlc_rd_t;

  localparam logic [5:0] ScanOrder [64] = '{
    6'd0,  6'd8,  6'd1,  6'd2,  6'd9,  6'd16, 6'd24, 6'd17,
    6'd10, 6'd3,  6'd4,  6'd11, 6'd18, 6'd25, 6'd32, 6'd40,
    6'd33, 6'd26, 6'd19, 6'd12, 6'd5,  6'd6,  6'd13, 6'd20,
    6'd27, 6'd34, 6'd41, 6'd48, 6'd56, 6'd49, 6'd42, 6'd35,
    6'd28, 6'd21, 6'd14, 6'd7,  6'd15, 6'd22, 6'd29, 6'd36,
    6'd43, 6'd50, 6'd57, 6'd58, 6'd51, 6'd44, 6'd37, 6'd30,
    6'd23, 6'd31, 6'd38, 6'd45, 6'd52, 6'd59, 6'd60, 6'd53,
    6'd46, 6'd39, 6'd47, 6'd54, 6'd61, 6'd62, 6'd55, 6'd63
  };

endpackage

// ===== rtl/dcvlc_cmd_if.sv =====
// input channel: bitstream words and table load words
// no dependencies
interface dcvlc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] stream_word;
  logic [8:0]  table_addr;
  logic [31:0] table_value;

  modport source (output valid, action, stream_word, table_addr, table_value, input ready);
  modport sink   (input valid, action, stream_word, table_addr, table_value, output ready);
endinterface

// ===== rtl/dcvlc_coef_if.sv =====
// output channel: decoded coefficient words and block end markers
// no dependencies
interface dcvlc_coef_if;
  logic               valid;
  logic               ready;
  logic [5:0]         position;
  logic signed [25:0] coefficient;
  logic               block_end;
  logic [6:0]         coded_count;
  logic               overrun_error;

  modport source (output valid, position, coefficient, block_end, coded_count,
                  overrun_error, input ready);
  modport sink   (input valid, position, coefficient, block_end, coded_count,
                  overrun_error, output ready);
endinterface

// ===== rtl/dct_coefficient_vlc_decoder.sv =====
// dct coefficient vlc decoder top: bit buffer, decode sequencer, output register
// depends on dcvlc_pkg, dcvlc_cmd_if, dcvlc_coef_if, dcvlc_mem
//
// cmd_i takes one word per handshake. action 1..3 writes a code table entry,
// action 4 writes a quant entry (low 16 bits), action 0 appends 16 bitstream
// bits below the held bits, bit 15 first. a word arriving with more than 32
// bits held is dropped.
// after a bitstream word the block decodes codes while at least 22 bits are
// held, at most 16 result words per bitstream word. each block begins with an
// 8-bit signed dc value, then run/level codes until end of block or overrun.
// coef_o carries position, coefficient, block_end, coded_count, overrun_error.
// per code the sequencer steps through a check, the first table read, an
// optional second or third table read, the run update, the quant read with
// multiply, and the output load; the dc value goes from the check to the
// quant read, an end of block code from the first table read to the output
// load, and an overrun from the run update to the output load.
// cmd_i is ready only while the sequencer is idle.
// if the receiver stalls, the sequencer holds in its output state and the
// result stays in the output register until taken.
// reset empties the buffer, clears the output valid and arms dc decoding;
// the tables are not cleared and must be loaded before use.
module dct_coefficient_vlc_decoder import dcvlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcvlc_cmd_if.sink   cmd_i,
  dcvlc_coef_if.source coef_o
);

  dcvlc_state_e state_q, state_d;
  logic [BufBits-1:0]  buf_q, buf_d;
  logic [5:0]          held_q, held_d;
  logic [6:0]          idx_q, idx_d;
  logic                dc_q, dc_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [31:0]         ent_q, ent_d;
  logic [8:0]          len_q, len_d;
  logic                third_q, third_d;
  logic signed [9:0]   lvl_q, lvl_d;
  logic [5:0]          pos_q, pos_d;
  logic [5:0]          res_pos_q, res_pos_d;
  logic signed [25:0]  res_coef_q, res_coef_d;
  logic                res_end_q, res_end_d;
  logic [6:0]          res_cnt_q, res_cnt_d;
  logic                res_err_q, res_err_d;
  logic                ov_q, ov_d;
  logic [5:0]          o_pos_q, o_pos_d;
  logic signed [25:0]  o_coef_q, o_coef_d;
  logic                o_end_q, o_end_d;
  logic [6:0]          o_cnt_q, o_cnt_d;
  logic                o_err_q, o_err_d;

  dcvlc_wr_t             wr;
  dcvlc_rd_t             rd;
  logic [31:0]           first_rd, second_rd, third_rd, sub_rd;
  logic [QuantWidth-1:0] quant_rd;

  logic [8:0]         drop_req;
  logic [5:0]         drop_n;
  logic               accept;
  logic [6:0]         sum;
  logic signed [26:0] prod;

  dcvlc_mem u_mem (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_i     (rd),
    .first_o  (first_rd),
    .second_o (second_rd),
    .third_o  (third_rd),
    .quant_o  (quant_rd)
  );

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign drop_n   = (drop_req > {3'b0, held_q}) ? held_q : drop_req[5:0];
  assign sum      = idx_q + {1'b0, ent_q[21:16]};
  assign sub_rd   = third_q ? third_rd : second_rd;
  assign prod     = lvl_q * $signed({1'b0, quant_rd});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      buf_q   <= '0;
      held_q  <= '0;
      idx_q   <= '0;
      dc_q    <= 1'b1;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      idx_q   <= idx_d;
      dc_q    <= dc_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    len_q      <= len_d;
    third_q    <= third_d;
    lvl_q      <= lvl_d;
    pos_q      <= pos_d;
    res_pos_q  <= res_pos_d;
    res_coef_q <= res_coef_d;
    res_end_q  <= res_end_d;
    res_cnt_q  <= res_cnt_d;
    res_err_q  <= res_err_d;
    o_pos_q    <= o_pos_d;
    o_coef_q   <= o_coef_d;
    o_end_q    <= o_end_d;
    o_cnt_q    <= o_cnt_d;
    o_err_q    <= o_err_d;
  end

  always_comb begin
    state_d    = state_q;
    buf_d      = buf_q;
    held_d     = held_q;
    idx_d      = idx_q;
    dc_d       = dc_q;
    cnt_d      = cnt_q;
    ent_d      = ent_q;
    len_d      = len_q;
    third_d    = third_q;
    lvl_d      = lvl_q;
    pos_d      = pos_q;
    res_pos_d  = res_pos_q;
    res_coef_d = res_coef_q;
    res_end_d  = res_end_q;
    res_cnt_d  = res_cnt_q;
    res_err_d  = res_err_q;
    o_pos_d    = o_pos_q;
    o_coef_d   = o_coef_q;
    o_end_d    = o_end_q;
    o_cnt_d    = o_cnt_q;
    o_err_d    = o_err_q;
    ov_d       = ov_q && !coef_o.ready;
    drop_req   = '0;
    cmd_i.ready = (state_q == ST_IDLE);
    wr.first_we  = 1'b0;
    wr.second_we = 1'b0;
    wr.third_we  = 1'b0;
    wr.quant_we  = 1'b0;
    wr.addr      = cmd_i.table_addr;
    wr.value     = cmd_i.table_value;
    rd.first_addr = buf_q[BufBits-1 -: FirstAw];
    rd.sub_addr   = buf_q[BufBits-1-MaxShortLen -: SubAw];
    rd.quant_addr = pos_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (dcvlc_action_e'(cmd_i.action))
            ACT_WORD: begin
              if (held_q <= 6'(BufBits - 16)) begin
                buf_d  = buf_q | ({cmd_i.stream_word, 32'b0} >> held_q);
                held_d = held_q + 6'd16;
              end
              cnt_d   = '0;
              state_d = ST_CHECK;
            end
            ACT_LOAD_FIRST:  wr.first_we  = 1'b1;
            ACT_LOAD_SECOND: wr.second_we = (cmd_i.table_addr < 9'(SubTableDepth));
            ACT_LOAD_THIRD:  wr.third_we  = (cmd_i.table_addr < 9'(SubTableDepth));
            ACT_LOAD_QUANT:  wr.quant_we  = (cmd_i.table_addr < 9'(QuantDepth));
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (cnt_q == 5'(ResultLimit) || held_q < 6'(NeedBits)) begin
          state_d = ST_IDLE;
        end else if (dc_q) begin
          lvl_d         = {{2{buf_q[BufBits-1]}}, buf_q[BufBits-1 -: DcLen]};
          drop_req      = 9'(DcLen);
          dc_d          = 1'b0;
          idx_d         = 7'd1;
          pos_d         = '0;
          rd.quant_addr = '0;
          state_d       = ST_QUANT;
        end else begin
          state_d = ST_TAB1;
        end
      end
      ST_TAB1: begin
        if (first_rd[7:0] > 8'(MaxShortLen)) begin
          if (!first_rd[FlagEscBit]) begin
            // second table after a 9-bit prefix, third after a 6-bit one
            third_d = first_rd[FlagSubBit];
            if (first_rd[FlagSubBit]) begin
              rd.sub_addr = buf_q[BufBits-1-6 -: SubAw];
            end
            state_d = ST_TAB2;
          end else if (first_rd[FlagSubBit]) begin
            drop_req  = 9'(EobLen);
            res_pos_d = '0;
            res_coef_d = '0;
            res_end_d = 1'b1;
            res_cnt_d = idx_q;
            res_err_d = 1'b0;
            dc_d      = 1'b1;
            idx_d     = '0;
            state_d   = ST_EMIT;
          end else begin
            ent_d   = {buf_q[BufBits-1-6 -: 16], 16'b0};
            len_d   = 9'(EscLen);
            state_d = ST_APPLY;
          end
        end else begin
          ent_d   = first_rd;
          len_d   = {1'b0, first_rd[7:0]};
          state_d = ST_APPLY;
        end
      end
      ST_TAB2: begin
        ent_d   = sub_rd;
        len_d   = (third_q ? 9'd6 : 9'(MaxShortLen)) + {1'b0, sub_rd[7:0]};
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        drop_req = len_q;
        if (sum > 7'(LastIndex)) begin
          res_pos_d  = '0;
          res_coef_d = '0;
          res_end_d  = 1'b1;
          res_cnt_d  = 7'(LastIndex + 1);
          res_err_d  = 1'b1;
          dc_d       = 1'b1;
          idx_d      = '0;
          state_d    = ST_EMIT;
        end else begin
          pos_d         = ScanOrder[sum[5:0]];
          rd.quant_addr = ScanOrder[sum[5:0]];
          lvl_d         = ent_q[31:22];
          idx_d         = sum + 7'd1;
          state_d       = ST_QUANT;
        end
      end
      ST_QUANT: begin
        res_pos_d  = pos_q;
        res_coef_d = prod[25:0];
        res_end_d  = 1'b0;
        res_cnt_d  = '0;
        res_err_d  = 1'b0;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || coef_o.ready) begin
          ov_d     = 1'b1;
          o_pos_d  = res_pos_q;
          o_coef_d = res_coef_q;
          o_end_d  = res_end_q;
          o_cnt_d  = res_cnt_q;
          o_err_d  = res_err_q;
          cnt_d    = cnt_q + 5'd1;
          state_d  = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // consume bits, never more than are held
    if (drop_req != '0) begin
      buf_d  = buf_q << drop_n;
      held_d = held_q - drop_n;
    end
  end

  assign coef_o.valid         = ov_q;
  assign coef_o.position      = o_pos_q;
  assign coef_o.coefficient   = o_coef_q;
  assign coef_o.block_end     = o_end_q;
  assign coef_o.coded_count   = o_cnt_q;
  assign coef_o.overrun_error = o_err_q;

`ifndef NO_ASSERTIONS
  held_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 6'(BufBits)) else $error("bit count beyond buffer size");

  result_limit_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(ResultLimit)) else $error("too many results for one word");

  index_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 7'(LastIndex + 1)) else $error("scan index out of range");

  overrun_marker_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && o_err_q |-> o_end_q && o_cnt_q == 7'(LastIndex + 1))
    else $error("overrun flagged on a word that is not an overrun marker");

  dc_quant_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QUANT |-> $past(state_q) == ST_CHECK || $past(state_q) == ST_APPLY)
    else $error("quant stage entered without a read issued");
`endif

endmodule

// ===== rtl/dcvlc_mem.sv =====
// code tables and quant table, synchronous registered read
// depends on dcvlc_pkg
module dcvlc_mem import dcvlc_pkg::*; (
  input  logic                  clk_i,
  input  dcvlc_wr_t             wr_i,
  input  dcvlc_rd_t             rd_i,
  output logic [31:0]           first_o,
  output logic [31:0]           second_o,
  output logic [31:0]           third_o,
  output logic [QuantWidth-1:0] quant_o
);

  logic [31:0]           first_mem  [FirstTableDepth];
  logic [31:0]           second_mem [SubTableDepth];
  logic [31:0]           third_mem  [SubTableDepth];
  logic [QuantWidth-1:0] quant_mem  [QuantDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.first_we) begin
      first_mem[wr_i.addr] <= wr_i.value;
    end
    if (wr_i.second_we) begin
      second_mem[wr_i.addr[SubAw-1:0]] <= wr_i.value;
    end
    if (wr_i.third_we) begin
      third_mem[wr_i.addr[SubAw-1:0]] <= wr_i.value;
    end
    if (wr_i.quant_we) begin
      quant_mem[wr_i.addr[QuantAw-1:0]] <= wr_i.value[QuantWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    first_o  <= first_mem[rd_i.first_addr];
    second_o <= second_mem[rd_i.sub_addr];
    third_o  <= third_mem[rd_i.sub_addr];
    quant_o  <= quant_mem[rd_i.quant_addr];
  end

endmodule

// ===== bench/dct_coefficient_vlc_decoder_tb.sv =====
// testbench for the dct coefficient vlc decoder: directed and random bitstreams
// checked word by word against a behavioral decoder kept in this file
// depends on dcvlc_pkg, dcvlc_cmd_if, dcvlc_coef_if and the decoder rtl
module dct_coefficient_vlc_decoder_tb;
  import dcvlc_pkg::*;

  typedef struct packed {
    logic [5:0]         position;
    logic signed [25:0] coefficient;
    logic               block_end;
    logic [6:0]         coded_count;
    logic               overrun_error;
  } coef_word_t;

  logic clk_i;
  logic rst_ni;
  dcvlc_cmd_if  cmd();
  dcvlc_coef_if coef();

  dct_coefficient_vlc_decoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd.sink),
    .coef_o(coef.source)
  );

  // decoder state mirror
  logic [47:0] buf_bits;
  int unsigned held_bits;
  int unsigned scan_idx;
  bit          want_dc;
  logic [31:0] vlc_first  [512];
  logic [31:0] vlc_second [256];
  logic [31:0] vlc_third  [256];
  logic [15:0] quant_mem  [64];

  coef_word_t expected_words[$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] peek(int unsigned off, int unsigned n);
    logic [47:0] t;
    t = buf_bits >> (48 - off - n);
    return 32'(t & ((48'd1 << n) - 48'd1));
  endfunction

  function automatic void drop(int unsigned n);
    if (n > held_bits) n = held_bits;
    buf_bits  = buf_bits << n;
    held_bits = held_bits - n;
  endfunction

  function automatic void push_word(logic [5:0] pos, longint coefv, bit fin,
                                    int unsigned cnt, bit err);
    coef_word_t w;
    w.position      = pos;
    w.coefficient   = 26'(coefv);
    w.block_end     = fin;
    w.coded_count   = 7'(cnt);
    w.overrun_error = err;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_decode(logic [2:0] act, logic [15:0] sw,
                                         logic [8:0] addr, logic [31:0] val);
    int          n;
    logic [31:0] ent;
    int unsigned len, run, idx;
    logic [9:0]  lvl;
    logic [5:0]  pos;
    longint      dc;
    n = 0;
    case (act)
      ACT_LOAD_FIRST:  begin vlc_first[addr] = val; return; end
      ACT_LOAD_SECOND: begin if (addr < 256) vlc_second[addr[7:0]] = val; return; end
      ACT_LOAD_THIRD:  begin if (addr < 256) vlc_third[addr[7:0]] = val; return; end
      ACT_LOAD_QUANT:  begin if (addr < 64) quant_mem[addr[5:0]] = val[15:0]; return; end
      ACT_WORD: ;
      default: return;
    endcase
    if (held_bits <= 32) begin
      buf_bits  = buf_bits | (48'(sw) << (32 - held_bits));
      held_bits = held_bits + 16;
    end
    while (n < ResultLimit && held_bits >= NeedBits) begin
      if (want_dc) begin
        dc = $signed(8'(peek(0, 8)));
        drop(8);
        push_word(6'd0, dc * longint'(quant_mem[0]), 1'b0, 0, 1'b0);
        n++;
        want_dc  = 0;
        scan_idx = 1;
        continue;
      end
      ent = vlc_first[peek(0, 9)];
      len = 32'(ent[7:0]);
      if (len > 9) begin
        if (!ent[5]) begin
          if (!ent[4]) begin
            ent = vlc_second[peek(9, 8)];
            len = 9 + 32'(ent[7:0]);
          end else begin
            ent = vlc_third[peek(6, 8)];
            len = 6 + 32'(ent[7:0]);
          end
        end else if (ent[4]) begin
          drop(2);
          push_word(6'd0, 0, 1'b1, scan_idx, 1'b0);
          n++;
          want_dc  = 1;
          scan_idx = 0;
          continue;
        end else begin
          ent = peek(6, 16) << 16;
          len = 22;
        end
      end
      drop(len);
      run = 32'(ent[21:16]);
      lvl = ent[31:22];
      idx = scan_idx + run;
      n++;
      if (idx > 63) begin
        push_word(6'd0, 0, 1'b1, 64, 1'b1);
        want_dc  = 1;
        scan_idx = 0;
        continue;
      end
      pos = ScanOrder[idx];
      push_word(pos, longint'($signed(lvl)) * longint'(quant_mem[pos]), 1'b0, 0, 1'b0);
      scan_idx = idx + 1;
    end
  endfunction

  task automatic send_word(logic [2:0] act, logic [15:0] sw, logic [8:0] addr,
                           logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid       <= 1'b1;
    cmd.action      <= act;
    cmd.stream_word <= sw;
    cmd.table_addr  <= addr;
    cmd.table_value <= val;
    do @(posedge clk_i); while (!cmd.ready);
    predict_decode(act, sw, addr, val);
  endtask

  // receiver side: random stall and compare
  always @(posedge clk_i) begin
    coef_word_t got, exp_w;
    if (rst_ni) begin
      if (coef.valid && coef.ready) begin
        got = {coef.position, coef.coefficient, coef.block_end, coef.coded_count,
               coef.overrun_error};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected pos %0d coef %0d end %0b cnt %0d err %0b,",
                        " got pos %0d coef %0d end %0b cnt %0d err %0b"},
                       exp_w.position, exp_w.coefficient, exp_w.block_end,
                       exp_w.coded_count, exp_w.overrun_error, got.position,
                       got.coefficient, got.block_end, got.coded_count,
                       got.overrun_error);
          end
        end
      end
      coef.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    int guard;
    guard = 0;
    cmd.valid <= 1'b0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  // table set: short codes, sub tables, escape and end of block.
  // first-table index = next 9 bits; we give every entry a definite code.
  // long entries use length 12, which carries neither flag bit
  task automatic load_tables();
    int unsigned e;
    for (int a = 0; a < 512; a++) begin
      case (a[8:6])
        3'd0: e = 32'h0c | 32'h30;                          // end of block, 2 bits
        3'd1: e = 32'h0c | 32'h20;                          // escape
        3'd2: e = 32'h0c;                                   // second table
        3'd3: e = 32'h0c | 32'h10;                          // third table
        default: e = ($urandom_range(9, 1)) | ($urandom_range(3) << 16)
                     | ($urandom_range(1023) << 22);
      endcase
      if (a == 511) e = 9 | (63 << 16) | (10'h1ff << 22);  // long run, max level
      if (a == 256) e = 3 | (0 << 16) | (10'h200 << 22);   // most negative level
      send_word(ACT_LOAD_FIRST, 16'($urandom), 9'(a), e);
    end
    for (int a = 0; a < 256; a++) begin
      send_word(ACT_LOAD_SECOND, 16'($urandom), 9'(a),
                $urandom_range(13, 1) | ($urandom_range(5) << 16) | ($urandom << 22));
      send_word(ACT_LOAD_THIRD, 16'($urandom), 9'(a),
                $urandom_range(16, 1) | ($urandom_range(7) << 16) | ($urandom << 22));
    end
    for (int a = 0; a < 64; a++)
      send_word(ACT_LOAD_QUANT, 16'($urandom), 9'(a),
                (a == 0) ? 32'hffff_ffff : (a == 1) ? 32'h0 : $urandom);
    // ignored addresses and unused actions
    send_word(ACT_LOAD_SECOND, 16'd0, 9'd300, 32'hdead);
    send_word(ACT_LOAD_THIRD, 16'd0, 9'd511, 32'hbeef);
    send_word(ACT_LOAD_QUANT, 16'd0, 9'd64, 32'h1234);
    send_word(3'd5, 16'hffff, 9'h1ff, 32'hffff_ffff);
    send_word(3'd6, 16'h0, 9'h0, 32'h0);
    send_word(3'd7, 16'h5555, 9'h0aa, 32'h5555_5555);
  endtask

  task automatic test_directed();
    send_word(ACT_WORD, 16'h7f00, 9'd0, 32'd0);  // dc max, then eob prefix bits
    send_word(ACT_WORD, 16'h8000, 9'd0, 32'd0);  // eob code, then dc of the next block
    send_word(ACT_WORD, 16'hffff, 9'd0, 32'd0);  // long-run overrun
    send_word(ACT_WORD, 16'hffff, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'h4000, 9'd0, 32'd0);  // another long-run overrun
    send_word(ACT_WORD, 16'h0000, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'h8000, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'h0000, 9'd0, 32'd0);  // many end of block codes
    send_word(ACT_WORD, 16'h0000, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'haaaa, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'h5555, 9'd0, 32'd0);
    send_word(ACT_WORD, 16'hc3c3, 9'd0, 32'd0);
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3)
        send_word(ACT_LOAD_QUANT, 16'd0, 9'($urandom_range(63)), $urandom);
      else
        send_word(ACT_WORD, 16'($urandom), 9'($urandom), $urandom);
    end
    drain();
  endtask

  initial begin
    mismatches      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    buf_bits        = '0;
    held_bits       = 0;
    scan_idx        = 0;
    want_dc         = 1;
    rst_ni          = 1'b0;
    cmd.valid       = 1'b0;
    cmd.action      = '0;
    cmd.stream_word = '0;
    cmd.table_addr  = '0;
    cmd.table_value = '0;
    coef.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_tables();
    test_directed();
    test_random(110, 0, 0);
    test_random(100, 73, 0);
    test_random(100, 0, 73);
    test_random(110, 32, 32);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
